// ===== hw/rtl/sgm_pkg.sv =====
// Package with the shared types and constants of the Sobel gradient magnitude core.
`timescale 1ns / 1ps
package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int CFG_W      = 10;
  localparam int SQ_W       = 22;
  localparam int REM_W      = 14;
  localparam int ROOT_W     = 11;
  localparam int ROOT_STEPS = 11;
  localparam int STEP_W     = 4;
  localparam int OUT_W      = 32;

  localparam logic [CFG_W-1:0]  LINE_WIDTH_RST = 10'd512;
  localparam int                MIN_LINE       = 3;
  localparam logic [PIX_W-1:0]  MAG_MAX        = 8'd255;
  localparam logic [1:0]        ROWS_FULL      = 2'd2;
  localparam logic [STEP_W-1:0] ROOT_LAST      = 4'(ROOT_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic take;
    logic shift_win;
    logic calc_grad;
    logic calc_sq;
    logic root_step;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/sobel_gradient_magnitude_core.sv =====
// Top level of the streaming Sobel 3x3 gradient magnitude core.
`timescale 1ns / 1ps
// The core takes zero-bordered 8-bit pixels in raster order, one transaction per pixel, and
// returns gx, gy and the floor square root of gx*gx+gy*gy saturated at 255 for every full
// 3x3 window. A pixel that yields no result occupies the core for the take and the window shift; a
// pixel that yields a result also occupies it for the gradient, the squares, the bit-serial square root
// unit that resolves one result bit per cycle, and any wait of the output register on out_tready.
// The next pixel is taken while a finished result waits in the output register.
// line_width must be written through the cfg channel only while the core is idle, which the core
// does not enforce itself; the line stores need no clearing pass after reset.
module sobel_gradient_magnitude_core #(
  parameter int MAX_LINE = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [sgm_pkg::PIX_W-1:0] in_tdata,   // [7:0] pixel_value
  input  logic                      in_tuser,   // [0] frame_start
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sgm_pkg::CFG_W-1:0] cfg_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sgm_pkg::OUT_W-1:0] out_tdata   // [7:0] magnitude, [18:8] grad_x, [29:19] grad_y
);
  import sgm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgm_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/sgm_ctrl.sv =====
// Controller state machine that sequences one pixel through the datapath.
`timescale 1ns / 1ps
module sgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sgm_pkg::ctrl_sts_t sts,
  output sgm_pkg::ctrl_cmd_t cmd
);
  import sgm_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift_win = 1'b1;
        state_nxt     = sts.item_valid ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd.calc_grad = 1'b1;
        state_nxt     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.calc_sq = 1'b1;
        step_nxt    = '0;
        state_nxt   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_take_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_SHIFT)
    else $error("accepted transaction did not move to the window shift");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROOT |-> step_r <= ROOT_LAST)
    else $error("root step count overran");

  a_hold_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) && sts.out_free |=> state_r == ST_IDLE)
    else $error("finished result not released to the output register");

endmodule

// ===== hw/rtl/sgm_datapath.sv =====
// Datapath with line stores, window, gradient, bit-serial root and output register.
`timescale 1ns / 1ps
module sgm_datapath #(
  parameter int MAX_LINE = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sgm_pkg::ctrl_cmd_t                cmd,
  output sgm_pkg::ctrl_sts_t                sts,
  input  logic [sgm_pkg::PIX_W-1:0]         in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgm_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sgm_pkg::OUT_W-1:0]         out_tdata
);
  import sgm_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int EW = (LW > CFG_W) ? LW : CFG_W;

  logic [PIX_W-1:0]  mem_a [MAX_LINE];
  logic [PIX_W-1:0]  mem_b [MAX_LINE];

  logic [CFG_W-1:0]  line_width_r;
  logic [AW-1:0]     col_r;
  logic [1:0]        rows_r;
  logic [AW-1:0]     addr_r;
  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  rd_a_r;
  logic [PIX_W-1:0]  rd_b_r;
  logic              valid_r;
  logic [PIX_W-1:0]  win_r [9];
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic [SQ_W-1:0]   val_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] res_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_mag_r;
  logic [GRAD_W-1:0] out_gx_r, out_gy_r;

  logic [EW-1:0]     lw_ext;
  logic [EW-1:0]     act_w;
  logic [AW-1:0]     col_cur;
  logic [1:0]        rows_cur;
  logic              wrap;
  logic signed [GRAD_W-1:0] w [9];
  logic signed [GRAD_W-1:0] gx_nxt, gy_nxt;
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]   sum_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic [PIX_W-1:0]  mag_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    lw_ext = EW'(line_width_r);
    if (lw_ext < EW'(MIN_LINE)) begin
      act_w = EW'(MIN_LINE);
    end else if (lw_ext > EW'(MAX_LINE)) begin
      act_w = EW'(MAX_LINE);
    end else begin
      act_w = lw_ext;
    end
    col_cur  = in_tuser ? '0 : col_r;
    rows_cur = in_tuser ? '0 : rows_r;
    wrap     = (EW'(col_cur) + EW'(1)) >= act_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      col_r        <= '0;
      rows_r       <= '0;
    end else begin
      if (cfg_valid) begin
        line_width_r <= cfg_data;
      end
      if (cmd.take) begin
        if (wrap) begin
          col_r <= '0;
          if (rows_cur != ROWS_FULL) begin
            rows_r <= rows_cur + 1'b1;
          end else begin
            rows_r <= rows_cur;
          end
        end else begin
          col_r  <= col_cur + 1'b1;
          rows_r <= rows_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_a_r        <= mem_a[col_cur];
      rd_b_r        <= mem_b[col_cur];
      mem_a[col_cur] <= in_tdata;
      addr_r        <= col_cur;
      pix_r         <= in_tdata;
      valid_r       <= (rows_cur == ROWS_FULL) && (col_cur >= AW'(2));
    end
    if (cmd.shift_win) begin
      mem_b[addr_r] <= rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.shift_win) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[2] <= rd_b_r;
      win_r[5] <= rd_a_r;
      win_r[8] <= pix_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      w[i] = $signed({{(GRAD_W-PIX_W){1'b0}}, win_r[i]});
    end
    gx_nxt  = (w[2] + (w[5] <<< 1) + w[8]) - (w[0] + (w[3] <<< 1) + w[6]);
    gy_nxt  = (w[0] + (w[1] <<< 1) + w[2]) - (w[6] + (w[7] <<< 1) + w[8]);
    sqx     = gx_r * gx_r;
    sqy     = gy_r * gy_r;
    sum_nxt = SQ_W'(sqx) + SQ_W'(sqy);
    rem_sh  = {rem_r[REM_W-3:0], val_r[SQ_W-1 -: 2]};
    trial   = {{(REM_W-ROOT_W-2){1'b0}}, res_r, 2'b01};
    mag_nxt = (res_r > ROOT_W'(MAG_MAX)) ? MAG_MAX : res_r[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_grad) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (cmd.calc_sq) begin
      val_r <= sum_nxt;
      rem_r <= '0;
      res_r <= '0;
    end else if (cmd.root_step) begin
      val_r <= {val_r[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial;
        res_r <= {res_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        res_r <= {res_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.publish) begin
      out_mag_r <= mag_nxt;
      out_gx_r  <= gx_r;
      out_gy_r  <= gy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.item_valid = valid_r;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {{(OUT_W-PIX_W-2*GRAD_W){1'b0}}, out_gy_r, out_gx_r, out_mag_r};

  a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r != 2'd3)
    else $error("row count passed saturation");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result missing from the output register");

  a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_gx_r == '0) && (out_gy_r == '0) |-> out_mag_r == '0)
    else $error("nonzero magnitude for a flat window");

endmodule
